@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the lookup cache RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define STFLC_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("stflc assertion failed");
`define STFLC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("stflc assertion failed");
`else
`define STFLC_ASSERT_PROP(lbl, clk, rst_n, prop)
`define STFLC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/stflc_pkg.sv @@
// Package of the swap-to-front lookup cache: field widths, command codes,
// defaults and the control struct shared by the controller and the cells.
package stflc_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int FIELD_W = 32;
    localparam int CAP_W   = 5;
    localparam int USED_W  = 5;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic shift;
        logic flush;
        logic commit;
        logic insert;
    } t_cell_ctl;

endpackage

@@ hw/rtl/stflc_req_if.sv @@
// Request channel of the lookup cache: command, key and value.
// Depends on stflc_pkg.
interface stflc_req_if;
    import stflc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

@@ hw/rtl/stflc_rsp_if.sv @@
// Response channel of the lookup cache: hit flag, value and fill count.
// Depends on stflc_pkg.
interface stflc_rsp_if;
    import stflc_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] found_value;
    logic [USED_W-1:0]  entries_used;

    modport source (output valid, hit, found_value, entries_used, input ready);
    modport sink   (input valid, hit, found_value, entries_used, output ready);
endinterface

@@ hw/rtl/stflc_cfg_if.sv @@
// Configuration write channel of the lookup cache (capacity register).
// Depends on stflc_pkg.
interface stflc_cfg_if;
    import stflc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/stflc_cell.sv @@
// One slot of the cache row: key/value storage, a probe stage of the scan
// chain and the key comparator. Depends on stflc_pkg.
module stflc_cell #(
    parameter int KEY_BITS   = stflc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = stflc_pkg::VALUE_BITS_DEF,
    parameter bit IS_HEAD    = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stflc_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_probe,
    output logic                  o_probe,
    input  logic                  i_wr_sel,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [KEY_BITS-1:0]   i_swap_key,
    input  logic [VALUE_BITS-1:0] i_swap_value,
    output logic                  o_match,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [KEY_BITS-1:0]   o_sel_key,
    output logic [VALUE_BITS-1:0] o_sel_value
);
    import stflc_pkg::*;

    logic                  r_probe;
    logic                  n_probe;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    always_comb begin
        n_probe = r_probe;
        if (i_ctl.flush) begin
            n_probe = 1'b0;
        end else if (i_ctl.shift) begin
            n_probe = i_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    // The head slot always takes the matched entry on a commit; any other
    // slot takes the old head only when it is the one that matched.
    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.commit && (IS_HEAD || o_match)) begin
            r_key   <= i_swap_key;
            r_value <= i_swap_value;
        end
    end

    assign o_probe     = r_probe;
    assign o_match     = r_probe && (r_key == i_key);
    assign o_key       = r_key;
    assign o_value     = r_value;
    assign o_sel_key   = {KEY_BITS{o_match}} & r_key;
    assign o_sel_value = {VALUE_BITS{o_match}} & r_value;

endmodule

@@ hw/rtl/stflc_ctrl.sv @@
// Sequencer of the lookup cache: request and response handshakes, capacity
// register, fill count and the scan over the cell row. Depends on stflc_pkg
// and the three channel interfaces.
module stflc_ctrl #(
    parameter int SLOTS      = stflc_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = stflc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = stflc_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stflc_req_if.sink             i_req,
    stflc_rsp_if.source           o_rsp,
    stflc_cfg_if.sink             i_cfg,
    output stflc_pkg::t_cell_ctl  o_ctl,
    output logic                  o_inject,
    output logic [SLOTS-1:0]      o_wr_sel,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    input  logic                  i_any_match,
    input  logic [VALUE_BITS-1:0] i_hit_value
);
    import stflc_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = CAP_W + CW;
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]            r_state,     n_state;
    logic [CMD_W-1:0]      r_cmd,       n_cmd;
    logic [KEY_BITS-1:0]   r_key,       n_key;
    logic [VALUE_BITS-1:0] r_value,     n_value;
    logic [CW-1:0]         r_idx,       n_idx;
    logic [CW-1:0]         r_fill,      n_fill;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_hit,   n_out_hit;
    logic [FIELD_W-1:0]    r_out_value, n_out_value;
    logic [USED_W-1:0]     r_out_used,  n_out_used;

    logic                  out_free;
    logic [XW-1:0]         cap_ext;
    logic [CW-1:0]         cap_eff;
    logic [CW-1:0]         ins_pos;
    logic [FIELD_W+KEY_BITS-1:0]   key_ext;
    logic [FIELD_W+VALUE_BITS-1:0] value_ext;
    logic [VALUE_BITS+FIELD_W-1:0] hit_ext;
    logic [CW+USED_W-1:0]          used_ext;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign key_ext   = {{KEY_BITS{1'b0}}, i_req.key};
    assign value_ext = {{VALUE_BITS{1'b0}}, i_req.value};
    assign hit_ext   = {{FIELD_W{1'b0}}, i_hit_value};

    // Capacity 0 acts as 1, anything above the slot count as the slot count.
    assign cap_ext = {{CW{1'b0}}, r_cap};
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > SLOTS_X) begin
            cap_eff = CW'(SLOTS);
        end else begin
            cap_eff = cap_ext[CW-1:0];
        end
    end

    assign ins_pos = (r_fill >= cap_eff) ? CW'(cap_eff - 1'b1) : r_fill;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            o_wr_sel[i] = o_ctl.insert && (ins_pos == CW'(i));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_value     = r_value;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_hit   = r_out_hit;
        n_out_value = r_out_value;
        o_ctl       = '0;
        o_inject    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.command;
                    n_key   = key_ext[KEY_BITS-1:0];
                    n_value = value_ext[VALUE_BITS-1:0];
                    if (i_req.command == CMD_LOOKUP) begin
                        o_inject    = 1'b1;
                        o_ctl.shift = 1'b1;
                        n_idx       = '0;
                        n_state     = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_value = '0;
                    case (r_cmd)
                        CMD_INSERT: begin
                            o_ctl.insert = 1'b1;
                            n_fill       = CW'(ins_pos + 1'b1);
                        end
                        CMD_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // The probe sits on slot r_idx; reaching the fill count is a miss.
                if (r_idx == r_fill) begin
                    if (out_free) begin
                        o_ctl.flush = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_hit   = 1'b0;
                        n_out_value = '0;
                        n_state     = S_IDLE;
                    end
                end else if (i_any_match) begin
                    if (out_free) begin
                        o_ctl.flush  = 1'b1;
                        o_ctl.commit = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_hit    = 1'b1;
                        n_out_value  = hit_ext[FIELD_W-1:0];
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_ctl.shift = 1'b1;
                    n_idx       = CW'(r_idx + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign used_ext   = {{USED_W{1'b0}}, n_fill};
    assign n_out_used = used_ext[USED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        if (n_out_valid && !(r_out_valid && !o_rsp.ready)) begin
            r_out_hit   <= n_out_hit;
            r_out_value <= n_out_value;
            r_out_used  <= n_out_used;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.found_value  = r_out_value;
    assign o_rsp.entries_used = r_out_used;
    assign o_key              = r_key;
    assign o_value            = r_value;

endmodule

@@ hw/rtl/swap_to_front_lookup_cache_top.sv @@
// Top level of the swap-to-front lookup cache: the sequencer and a row of
// slot cells joined by the probe chain. Depends on stflc_pkg, the channel
// interfaces, stflc_ctrl, stflc_cell and assert_macros.svh.
//
//   channel   direction  payload
//   i_req     in         command, key, value
//   o_rsp     out        hit, found_value, entries_used
//   i_cfg     in         capacity (write data)
//
// A lookup injects a probe at the head slot and registers its response when
// the probe stops: the probe walks one slot per cycle down the cell row
// and stops at the first match or at the fill count. Insert, clear and the
// unused code pass through the execute state before their response.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// A stalled response holds the sequencer in its last step; one further
// request may be taken while a finished response waits.
`include "assert_macros.svh"

module swap_to_front_lookup_cache_top #(
    parameter int SLOTS      = stflc_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = stflc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = stflc_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stflc_req_if.sink   i_req,
    stflc_rsp_if.source o_rsp,
    stflc_cfg_if.sink   i_cfg
);
    import stflc_pkg::*;

    t_cell_ctl             ctl;
    logic                  inject;
    logic [SLOTS-1:0]      wr_sel;
    logic [KEY_BITS-1:0]   bcast_key;
    logic [VALUE_BITS-1:0] bcast_value;
    logic [SLOTS:0]        probes;
    logic [SLOTS-1:0]      match;
    logic [KEY_BITS-1:0]   head_key;
    logic [VALUE_BITS-1:0] head_value;
    logic [KEY_BITS-1:0]   sel_key   [SLOTS];
    logic [VALUE_BITS-1:0] sel_value [SLOTS];
    logic [KEY_BITS-1:0]   bus_key;
    logic [VALUE_BITS-1:0] bus_value;

    stflc_ctrl #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg       (i_cfg),
        .o_ctl       (ctl),
        .o_inject    (inject),
        .o_wr_sel    (wr_sel),
        .o_key       (bcast_key),
        .o_value     (bcast_value),
        .i_any_match (|match),
        .i_hit_value (bus_value)
    );

    assign probes[0] = inject;

    generate
        for (genvar g = 0; g < SLOTS; g++) begin : g_cell
            if (g == 0) begin : g_head
                stflc_cell #(
                    .KEY_BITS   (KEY_BITS),
                    .VALUE_BITS (VALUE_BITS),
                    .IS_HEAD    (1'b1)
                ) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl),
                    .i_probe      (probes[g]),
                    .o_probe      (probes[g+1]),
                    .i_wr_sel     (wr_sel[g]),
                    .i_key        (bcast_key),
                    .i_value      (bcast_value),
                    .i_swap_key   (bus_key),
                    .i_swap_value (bus_value),
                    .o_match      (match[g]),
                    .o_key        (head_key),
                    .o_value      (head_value),
                    .o_sel_key    (sel_key[g]),
                    .o_sel_value  (sel_value[g])
                );
            end else begin : g_body
                stflc_cell #(
                    .KEY_BITS   (KEY_BITS),
                    .VALUE_BITS (VALUE_BITS),
                    .IS_HEAD    (1'b0)
                ) u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl),
                    .i_probe      (probes[g]),
                    .o_probe      (probes[g+1]),
                    .i_wr_sel     (wr_sel[g]),
                    .i_key        (bcast_key),
                    .i_value      (bcast_value),
                    .i_swap_key   (head_key),
                    .i_swap_value (head_value),
                    .o_match      (match[g]),
                    .o_key        (),
                    .o_value      (),
                    .o_sel_key    (sel_key[g]),
                    .o_sel_value  (sel_value[g])
                );
            end
        end
    endgenerate

    // At most one cell matches, so an OR of the masked outputs selects it.
    always_comb begin
        bus_key   = '0;
        bus_value = '0;
        for (int i = 0; i < SLOTS; i++) begin
            bus_key   = bus_key | sel_key[i];
            bus_value = bus_value | sel_value[i];
        end
    end

    `STFLC_ASSERT_PROP(a_single_probe, i_clk, i_rst_n, $onehot0(probes[SLOTS:1]))
    `STFLC_ASSERT_PROP(a_commit_one_match, i_clk, i_rst_n, ctl.commit |-> $onehot(match))
    `STFLC_ASSERT_PROP(a_flush_clears, i_clk, i_rst_n, ctl.flush |=> (probes[SLOTS:1] == '0))
    `STFLC_ASSERT_PROP(a_insert_one_slot, i_clk, i_rst_n, ctl.insert |-> $onehot(wr_sel))

endmodule
